>>> rtl/core/u8cc_pkg.sv
`default_nettype none

package u8cc_pkg;

   // payload widths fixed by the channel formats
   localparam int unsigned TEXT_BYTE_W  = 8;
   localparam int unsigned CHAR_COUNT_W = 16;
   localparam int unsigned CHAR_VALUE_W = 32;
   localparam int unsigned TARGET_W     = 16;

   // utf-8 byte classes: mask and match pattern
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_MATCH = 8'h80;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_MATCH = 8'hF0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_MATCH = 8'hE0;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_MATCH = 8'hC0;
   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] ASCII_MATCH = 8'h00;
   localparam logic [7:0] TERM_BYTE  = 8'h00;

   // status codes
   localparam logic STATUS_VALID     = 1'b0;
   localparam logic STATUS_MALFORMED = 1'b1;

   localparam logic [CHAR_VALUE_W-1:0] NOT_FOUND_VALUE = '1;

   // one result beat
   typedef struct packed {
      logic                    status;
      logic [CHAR_COUNT_W-1:0] char_count;
      logic                    found;
      logic [CHAR_VALUE_W-1:0] char_value;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> rtl/core/u8cc_req_if.sv
`default_nettype none

interface u8cc_req_if
   import u8cc_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [TEXT_BYTE_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/u8cc_rsp_if.sv
`default_nettype none

interface u8cc_rsp_if
   import u8cc_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic                    status;
   logic [CHAR_COUNT_W-1:0] char_count;
   logic                    found;
   logic [CHAR_VALUE_W-1:0] char_value;

   modport source (output valid, output status, output char_count, output found,
                   output char_value, input ready);
   modport sink (input valid, input status, input char_count, input found,
                 input char_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/u8cc_frame.sv
`default_nettype none

module u8cc_frame
   import u8cc_pkg::*;
#(
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [TEXT_BYTE_W-1:0] text_byte,
   input  wire logic [TARGET_W-1:0]    target_index,
   output rsp_payload_type             result
);

   localparam int unsigned WIDE_BITS = (COUNT_BITS > CHAR_COUNT_W) ? COUNT_BITS : CHAR_COUNT_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // per-string state
   logic [1:0]              pend_ff, pend_in;
   logic [CHAR_VALUE_W-1:0] acc_ff, acc_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    mal_ff, mal_in;
   logic [CHAR_VALUE_W-1:0] cap_val_ff, cap_val_in;
   logic                    cap_ff, cap_in;

   logic                    is_term;
   logic                    is_cont;
   logic                    finish;
   logic                    mal_final;
   logic                    ok;
   logic [WIDE_BITS-1:0]    count_wide;
   logic [CHAR_COUNT_W-1:0] count_sat;

   assign is_term    = (text_byte == TERM_BYTE);
   assign is_cont    = ((text_byte & CONT_MASK) == CONT_MATCH);
   assign count_wide = WIDE_BITS'(count_ff);

   // summary values for the terminator
   assign mal_final = mal_ff | (pend_ff != 2'd0);
   assign ok        = !mal_final && cap_ff;
   assign count_sat = (count_wide > WIDE_BITS'({CHAR_COUNT_W{1'b1}}))
                    ? {CHAR_COUNT_W{1'b1}} : count_wide[CHAR_COUNT_W-1:0];

   always_comb begin
      result.status     = mal_final ? STATUS_MALFORMED : STATUS_VALID;
      result.char_count = mal_final ? '0 : count_sat;
      result.found      = ok;
      result.char_value = ok ? cap_val_ff : NOT_FOUND_VALUE;
   end

   // sequence framing
   always_comb begin
      pend_in    = pend_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      mal_in     = mal_ff;
      cap_val_in = cap_val_ff;
      cap_in     = cap_ff;
      finish     = 1'b0;
      if (is_term) begin
         pend_in    = '0;
         acc_in     = '0;
         count_in   = '0;
         mal_in     = 1'b0;
         cap_val_in = '0;
         cap_in     = 1'b0;
      end else if (mal_ff) begin
         mal_in = 1'b1;
      end else if (pend_ff != 2'd0) begin
         if (!is_cont) begin
            mal_in = 1'b1;
         end else begin
            acc_in  = {acc_ff[CHAR_VALUE_W-TEXT_BYTE_W-1:0], text_byte};
            pend_in = pend_ff - 2'd1;
            finish  = (pend_ff == 2'd1);
         end
      end else begin
         acc_in = CHAR_VALUE_W'(text_byte);
         priority if (is_cont) begin
            mal_in = 1'b1;
         end else if ((text_byte & LEAD4_MASK) == LEAD4_MATCH) begin
            pend_in = 2'd3;
         end else if ((text_byte & LEAD3_MASK) == LEAD3_MATCH) begin
            pend_in = 2'd2;
         end else if ((text_byte & LEAD2_MASK) == LEAD2_MATCH) begin
            pend_in = 2'd1;
         end else if ((text_byte & ASCII_MASK) == ASCII_MATCH) begin
            finish = 1'b1;
         end else begin
            mal_in = 1'b1;
         end
      end
      // whole character: capture on first index match, count with saturation
      if (finish) begin
         if (!cap_ff && (count_wide == WIDE_BITS'(target_index))) begin
            cap_val_in = acc_in;
            cap_in     = 1'b1;
         end
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         acc_ff     <= '0;
         count_ff   <= '0;
         mal_ff     <= 1'b0;
         cap_val_ff <= '0;
         cap_ff     <= 1'b0;
      end else if (step) begin
         pend_ff    <= pend_in;
         acc_ff     <= acc_in;
         count_ff   <= count_in;
         mal_ff     <= mal_in;
         cap_val_ff <= cap_val_in;
         cap_ff     <= cap_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/u8cc_rsp_reg.sv
`default_nettype none

module u8cc_rsp_reg
   import u8cc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire rsp_payload_type load_data,
   output logic            can_load,
   u8cc_rsp_if.source      rsp_bus
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   // slot is free when empty or being drained this cycle
   assign can_load = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

   // result beat
   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.status     = data_ff.status;
   assign rsp_bus.char_count = data_ff.char_count;
   assign rsp_bus.found      = data_ff.found;
   assign rsp_bus.char_value = data_ff.char_value;

endmodule

`default_nettype wire

>>> rtl/core/utf8_char_count_and_pick_unit.sv
`default_nettype none

// UTF-8 character counter and picker. Bytes of a zero-terminated string arrive one per beat
// on req_bus and are taken at one byte per cycle. Each byte passes an input register, is framed
// against the sequence state, and the terminating zero byte loads one result beat into the
// output register on rsp_bus: status, saturated character count, found flag and the big-endian
// packed bytes of the character at csr target index. Input stalls only when a terminator waits
// for an output register that still holds an untaken result. Overlong forms and surrogates
// are not rejected. Write the target index only while no string is in flight.
module utf8_char_count_and_pick_unit
   import u8cc_pkg::*;
#(
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   u8cc_req_if.sink                 req_bus,
   u8cc_rsp_if.source               rsp_bus,
   input  wire logic                csr_wr_en,
   input  wire logic [TARGET_W-1:0] csr_wr_data
);

   logic                   in_valid_ff, in_valid_in;
   logic [TEXT_BYTE_W-1:0] in_byte_ff;
   logic [TARGET_W-1:0]    target_ff;
   logic                   in_is_term;
   logic                   step;
   logic                   can_load;
   logic                   req_take;
   rsp_payload_type        result;

   // target index register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   // input register and stall control
   assign in_is_term    = (in_byte_ff == TERM_BYTE);
   assign step          = in_valid_ff && (!in_is_term || can_load);
   assign req_bus.ready = !in_valid_ff || step;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_byte_ff <= req_bus.text_byte;
      end
   end

   u8cc_frame #(
      .COUNT_BITS (COUNT_BITS)
   ) u_frame (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .text_byte    (in_byte_ff),
      .target_index (target_ff),
      .result       (result)
   );

   u8cc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step && in_is_term),
      .load_data (result),
      .can_load  (can_load),
      .rsp_bus   (rsp_bus)
   );

`ifndef SYNTHESIS
   // a malformed string never reports a count or a pick
   a_malformed_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status == STATUS_MALFORMED)
      |-> !rsp_bus.found && (rsp_bus.char_count == '0))
      else $error("malformed result carries count or pick");

   // no pick reads as all ones
   a_not_found_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.found |-> (rsp_bus.char_value == NOT_FOUND_VALUE))
      else $error("not-found value is not all ones");

   // input stalls only behind a waiting terminator
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> in_valid_ff && in_is_term && rsp_bus.valid)
      else $error("input stalled without a waiting terminator");

   // a terminator that steps produces a result beat next cycle
   a_term_result: assert property (@(posedge clock) disable iff (reset)
      step && in_is_term |=> rsp_bus.valid)
      else $error("terminator did not produce a result");
`endif

endmodule

`default_nettype wire
